### sv/sv39_page_table_walker_top_defines.svh
`ifndef SV39_PAGE_TABLE_WALKER_TOP_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_TOP_DEFINES_SVH

// same-cycle implication
`define SV39_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SV39_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sv39ptw_pkg.sv
`timescale 1ns / 1ps

package sv39ptw_pkg;

  localparam int unsigned StorePagesDef = 8;
  localparam int unsigned WordsPerPage  = 512;
  localparam int unsigned PpnW          = 44;
  localparam int unsigned VaW           = 39;
  localparam int unsigned PaW           = 56;
  localparam int unsigned VpnW          = 9;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [CfgIdxW-1:0] CfgRootPage  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStoreBase = 1'b1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpXlate = 1'b1;

  localparam logic [2:0] StatusOk      = 3'd0;
  localparam logic [2:0] StatusHigh    = 3'd1;
  localparam logic [2:0] StatusInvalid = 3'd2;
  localparam logic [2:0] StatusNotUser = 3'd3;
  localparam logic [2:0] StatusOutside = 3'd4;

  localparam int unsigned PteV = 0;
  localparam int unsigned PteU = 4;

  typedef struct packed {
    logic          op;
    logic [11:0]   word_index;
    logic [63:0]   entry_value;
    logic [VaW-1:0] virt_addr;
  } req_t;

  typedef struct packed {
    logic [PaW-1:0] phys_page_addr;
    logic [2:0]     status;
  } rsp_t;

endpackage

### sv/sv39ptw_store.sv
`timescale 1ns / 1ps

module sv39ptw_store #(
  parameter int unsigned STORE_PAGES = sv39ptw_pkg::StorePagesDef,
  parameter int unsigned AW = $clog2(STORE_PAGES * sv39ptw_pkg::WordsPerPage)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);
  import sv39ptw_pkg::*;

  localparam int unsigned Depth = STORE_PAGES * WordsPerPage;

  logic [63:0] mem_q [Depth];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sv39_page_table_walker_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (op, word_index, entry_value, virt_addr)
// out     | output    | out_valid_o / out_stall_i| out_item_o (phys_page_addr, status)
// cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// Write item or too-high address: start state, then response state, then the output register.
// A translate adds, per level visited, a range check and read issue, then an entry check:
// three levels for a full walk, one when the root page is outside the store.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset clears control and config; the store is not cleared and reads back unknown
// until written. Output stall holds the result; the next item then waits in its last state.

`include "sv39_page_table_walker_top_defines.svh"

module sv39_page_table_walker_top #(
  parameter int unsigned STORE_PAGES = sv39ptw_pkg::StorePagesDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  sv39ptw_pkg::req_t                      in_item_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output sv39ptw_pkg::rsp_t                      out_item_o,
  input  logic                                   cfg_we_i,
  input  logic [sv39ptw_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sv39ptw_pkg::PpnW-1:0]           cfg_wdata_i
);
  import sv39ptw_pkg::*;

  localparam int unsigned Depth = STORE_PAGES * WordsPerPage;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SlotW = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StAddr  = 3'd2;
  localparam logic [2:0] StData  = 3'd3;
  localparam logic [2:0] StResp  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [1:0]      level_q, level_d;
  logic [PpnW-1:0] page_q, page_d;
  logic [PpnW-1:0] root_q, base_q;
  req_t            req_q;
  rsp_t            res_q, res_d;
  rsp_t            out_q;
  logic            out_valid_q, out_valid_d;

  logic [PpnW:0]     diff;
  logic              outside;
  logic [VpnW-1:0]   vpn;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic [63:0]       rd_data;
  logic              in_acc;
  logic              out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // shared page range check
  assign diff    = {1'b0, page_q} - {1'b0, base_q};
  assign outside = diff[PpnW] || (diff[PpnW-1:0] >= PpnW'(STORE_PAGES));

  always_comb begin
    case (level_q)
      2'd2:    vpn = req_q.virt_addr[38:30];
      2'd1:    vpn = req_q.virt_addr[29:21];
      default: vpn = req_q.virt_addr[20:12];
    endcase
  end

  assign rd_addr = AW'({diff[SlotW-1:0], vpn});
  assign rd_en   = (state_q == StAddr) && !outside;
  assign wr_en   = (state_q == StStart) && (req_q.op == OpWrite) &&
                   ({20'd0, req_q.word_index} < 32'(Depth));

  sv39ptw_store #(
    .STORE_PAGES(STORE_PAGES),
    .AW         (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AW'(req_q.word_index)),
    .wdata_i(req_q.entry_value),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    page_d      = page_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StStart;
        end
      end
      StStart: begin
        res_d   = '{phys_page_addr: '0, status: StatusOk};
        level_d = 2'd2;
        page_d  = root_q;
        if (req_q.op == OpWrite) begin
          state_d = StResp;
        end else if (req_q.virt_addr[38]) begin
          res_d.status = StatusHigh;
          state_d      = StResp;
        end else begin
          state_d = StAddr;
        end
      end
      StAddr: begin
        if (outside) begin
          res_d.status = StatusOutside;
          state_d      = StResp;
        end else begin
          state_d = StData;
        end
      end
      StData: begin
        if (!rd_data[PteV]) begin
          res_d.status = StatusInvalid;
          state_d      = StResp;
        end else begin
          page_d = rd_data[53:10];
          if (level_q == 2'd0) begin
            state_d = StResp;
            if (!rd_data[PteU]) begin
              res_d.status = StatusNotUser;
            end else begin
              res_d.phys_page_addr = {rd_data[53:10], 12'd0};
            end
          end else begin
            level_d = level_q - 2'd1;
            state_d = StAddr;
          end
        end
      end
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRootPage:  root_q <= cfg_wdata_i;
          CfgStoreBase: base_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    page_q  <= page_d;
    res_q   <= res_d;
    if (in_acc) begin
      req_q <= in_item_i;
    end
    if ((state_q == StResp) && out_free) begin
      out_q <= res_q;
    end
  end

  `SV39_ASSERT_NOW(a_fault_zero_addr, clk_i, rst_ni,
    out_valid_o && (out_item_o.status != StatusOk), out_item_o.phys_page_addr == '0,
    "faulting result carries a nonzero address")
  `SV39_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni,
    in_acc, state_q == StStart, "accepted item did not start the sequencer")
  `SV39_ASSERT_NEXT(a_read_then_check, clk_i, rst_ni,
    rd_en, state_q == StData && in_stall_o, "store read not followed by entry check")
  `SV39_ASSERT_NEXT(a_out_drains, clk_i, rst_ni,
    out_valid_o && !out_stall_i && (state_q != StResp), !out_valid_o,
    "taken result shown again")

endmodule
